>>> hw/rtl/bmpc_pkg.sv
// ----------------------------------------------------------------------------
// bmpc_pkg
// Shared types, step codes and helpers for the barometric compensation block.
// ----------------------------------------------------------------------------
package bmpc_pkg;

   localparam int TRIM_W = 48;
   localparam int ADC_W  = 20;
   localparam int RES_W  = 19;

   localparam logic [2:0] CSR_TEMP_TRIM    = 3'd0;
   localparam logic [2:0] CSR_PRESS_TRIM_A = 3'd1;
   localparam logic [2:0] CSR_PRESS_TRIM_B = 3'd2;
   localparam logic [2:0] CSR_PRESS_TRIM_C = 3'd3;

   localparam logic [RES_W-1:0] OUT_MIN = 19'h78000;   // -32768
   localparam logic [RES_W-1:0] OUT_MAX = 19'h3FFFF;   // 262143

   typedef enum logic [4:0] {
      T_A, T_M1, T_M2, T_S, T_M3, T_F, T_R,
      P_A, P_M1, P_M2, P_M3, P_S1, P_M4, P_M5, P_S2, P_M6, P_S3, P_CHK,
      P_M7, P_DIV, P_S4, P_M8, P_M9, P_M10, P_S5, P_S6, P_S7, P_S8
   } step_type;

   typedef enum logic [2:0] {
      KIND_ALU, KIND_LAST, KIND_MUL, KIND_DIV, KIND_CHK
   } kind_type;

   typedef struct packed {
      logic     load;
      logic     issue;
      logic     retire;
      logic     publish;
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic den_zero;
   } status_type;

   function automatic kind_type step_kind(step_type s);
      kind_type k;
      case (s)
         T_M1, T_M2, T_M3, P_M1, P_M2, P_M3, P_M4, P_M5, P_M6, P_M7,
         P_M8, P_M9, P_M10: k = KIND_MUL;
         P_DIV:             k = KIND_DIV;
         P_CHK:             k = KIND_CHK;
         T_R, P_S8:         k = KIND_LAST;
         default:           k = KIND_ALU;
      endcase
      return k;
   endfunction

   function automatic logic [63:0] sx16(logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   function automatic logic [63:0] sx32(logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic [31:0] asr32(logic [31:0] x, logic [5:0] s);
      return 32'($signed(x) >>> s);
   endfunction

   function automatic logic [63:0] asr64(logic [63:0] x, logic [5:0] s);
      return 64'($signed(x) >>> s);
   endfunction

   function automatic logic [RES_W-1:0] saturate(logic [63:0] v);
      logic [RES_W-1:0] r;
      if (v[63] && ($signed(v) < -64'sd32768))
         r = OUT_MIN;
      else if (!v[63] && (v > 64'd262143))
         r = OUT_MAX;
      else
         r = v[RES_W-1:0];
      return r;
   endfunction

endpackage

>>> hw/rtl/bmpc_mul.sv
// ----------------------------------------------------------------------------
// bmpc_mul
// Shared 64-bit multiplier, low 64 bits of the product, 16 bits per cycle.
// ----------------------------------------------------------------------------
module bmpc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [79:0] part;

   assign part = {16'd0, a_ff} * {64'd0, b_ff[15:0]};

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         acc_in  = 64'd0;
         a_in    = op_a;
         b_in    = op_b;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         acc_in = acc_ff + part[63:0];
         a_in   = a_ff << 16;
         b_in   = b_ff >> 16;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      if (reset) begin
         cnt_ff  <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> hw/rtl/bmpc_div.sv
// ----------------------------------------------------------------------------
// bmpc_div
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmpc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quot
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [65:0] diff;

   assign diff = {1'b0, rem_ff, quo_ff[63]} - {2'b00, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = 64'd0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // diff[65] is the borrow: trial subtract failed
         if (diff[65])
            rem_in = {rem_ff[62:0], quo_ff[63]};
         else
            rem_in = diff[63:0];
         quo_in = {quo_ff[62:0], ~diff[65]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= 6'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

>>> hw/rtl/bmpc_datapath.sv
// ----------------------------------------------------------------------------
// bmpc_datapath
// Trim registers, working registers, shared multiplier and divider.
// ----------------------------------------------------------------------------
module bmpc_datapath
   import bmpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [23:0]             raw_reading,
   input  logic                    csr_write,
   input  logic [2:0]              csr_index,
   input  logic [TRIM_W-1:0]       csr_data,
   output logic signed [RES_W-1:0] result_value,
   output logic                    divide_fault
);

   logic [TRIM_W-1:0] temp_trim_ff, press_a_ff, press_b_ff, press_c_ff;
   logic [ADC_W-1:0]  adc_ff, adc_in;
   logic [63:0]       a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   logic [31:0]       fine_ff, fine_in;
   logic [RES_W-1:0]  res_ff, res_in, out_val_ff;
   logic              flt_ff, flt_in, out_flt_ff;
   logic              qneg_ff, qneg_in;

   logic [63:0] t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [63:0] mul_a, mul_b, mul_p, div_q;
   logic        mul_start, div_start, mul_done, div_done;
   logic [31:0] t5;
   logic [63:0] abs_b, abs_a;

   assign t2 = sx16(temp_trim_ff[31:16]);
   assign t3 = sx16(temp_trim_ff[47:32]);
   assign p1 = {48'd0, press_a_ff[15:0]};
   assign p2 = sx16(press_a_ff[31:16]);
   assign p3 = sx16(press_a_ff[47:32]);
   assign p4 = sx16(press_b_ff[15:0]);
   assign p5 = sx16(press_b_ff[31:16]);
   assign p6 = sx16(press_b_ff[47:32]);
   assign p7 = sx16(press_c_ff[15:0]);
   assign p8 = sx16(press_c_ff[31:16]);
   assign p9 = sx16(press_c_ff[47:32]);

   assign abs_b = b_ff[63] ? (64'd0 - b_ff) : b_ff;
   assign abs_a = a_ff[63] ? (64'd0 - a_ff) : a_ff;
   assign t5    = (fine_ff << 2) + fine_ff + 32'd128;

   assign mul_start = cmd.issue && (step_kind(cmd.step) == KIND_MUL);
   assign div_start = cmd.issue && (step_kind(cmd.step) == KIND_DIV);

   always_comb begin
      mul_a = a_ff;
      mul_b = a_ff;
      case (cmd.step)
         T_M1:    begin mul_a = a_ff; mul_b = t2;   end
         T_M2:    begin mul_a = b_ff; mul_b = b_ff; end
         T_M3:    begin mul_a = d_ff; mul_b = t3;   end
         P_M1:    begin mul_a = a_ff; mul_b = a_ff; end
         P_M2:    begin mul_a = c_ff; mul_b = p6;   end
         P_M3:    begin mul_a = a_ff; mul_b = p5;   end
         P_M4:    begin mul_a = c_ff; mul_b = p3;   end
         P_M5:    begin mul_a = a_ff; mul_b = p2;   end
         P_M6:    begin mul_a = a_ff; mul_b = p1;   end
         P_M7:    begin mul_a = b_ff; mul_b = 64'd3125; end
         P_M8:    begin mul_a = p9;   mul_b = c_ff; end
         P_M9:    begin mul_a = e_ff; mul_b = c_ff; end
         P_M10:   begin mul_a = p8;   mul_b = b_ff; end
         default: begin mul_a = a_ff; mul_b = a_ff; end
      endcase
   end

   bmpc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   bmpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (abs_b),
      .den   (abs_a),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      adc_in  = adc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      d_in    = d_ff;
      e_in    = e_ff;
      fine_in = fine_ff;
      res_in  = res_ff;
      flt_in  = flt_ff;
      qneg_in = qneg_ff;
      if (cmd.load) begin
         adc_in = raw_reading[23:4];
      end else if (cmd.issue) begin
         case (cmd.step)
            T_A: begin
               a_in = sx32({15'd0, adc_ff[19:3]} - {15'd0, temp_trim_ff[15:0], 1'b0});
               b_in = sx32({16'd0, adc_ff[19:4]} - {16'd0, temp_trim_ff[15:0]});
            end
            T_S: begin
               c_in = sx32(asr32(c_ff[31:0], 6'd11));
               d_in = sx32(asr32(d_ff[31:0], 6'd12));
            end
            T_F: fine_in = c_ff[31:0] + asr32(d_ff[31:0], 6'd14);
            T_R: begin
               res_in = saturate(sx32(asr32(t5, 6'd8)));
               flt_in = 1'b0;
            end
            P_A: begin
               a_in = sx32(fine_ff) - 64'd128000;
               b_in = 64'd1048576 - {44'd0, adc_ff};
            end
            P_S1: d_in = d_ff + (e_ff << 17) + (p4 << 35);
            P_S2: a_in = asr64(c_ff, 6'd8) + (e_ff << 12) + (64'd1 << 47);
            P_S3: a_in = asr64(a_ff, 6'd33);
            P_CHK: begin
               if (a_ff == 64'd0) begin
                  res_in = '0;
                  flt_in = 1'b1;
               end else begin
                  b_in = (b_ff << 31) - d_ff;
               end
            end
            P_DIV: qneg_in = b_ff[63] ^ a_ff[63];
            P_S4:  c_in = asr64(b_ff, 6'd13);
            P_S5:  b_in = b_ff + asr64(e_ff, 6'd25) + asr64(d_ff, 6'd19);
            P_S6:  b_in = asr64(b_ff, 6'd8) + (p7 << 4);
            P_S7:  e_in = abs_b >> 8;   // magnitude, truncation toward zero
            P_S8: begin
               res_in = saturate(b_ff[63] ? (64'd0 - e_ff) : e_ff);
               flt_in = 1'b0;
            end
            default: ;
         endcase
      end else if (cmd.retire) begin
         case (cmd.step)
            T_M1:    c_in = mul_p;
            T_M2:    d_in = mul_p;
            T_M3:    d_in = mul_p;
            P_M1:    c_in = mul_p;
            P_M2:    d_in = mul_p;
            P_M3:    e_in = mul_p;
            P_M4:    c_in = mul_p;
            P_M5:    e_in = mul_p;
            P_M6:    a_in = mul_p;
            P_M7:    b_in = mul_p;
            P_DIV:   b_in = qneg_ff ? (64'd0 - div_q) : div_q;
            P_M8:    e_in = mul_p;
            P_M9:    e_in = mul_p;
            P_M10:   d_in = mul_p;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      adc_ff  <= adc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      res_ff  <= res_in;
      flt_ff  <= flt_in;
      qneg_ff <= qneg_in;
      if (cmd.publish) begin
         out_val_ff <= res_ff;
         out_flt_ff <= flt_ff;
      end
      if (reset) begin
         fine_ff      <= 32'd0;
         temp_trim_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
      end else begin
         fine_ff <= fine_in;
         if (csr_write) begin
            case (csr_index)
               CSR_TEMP_TRIM:    temp_trim_ff <= csr_data;
               CSR_PRESS_TRIM_A: press_a_ff   <= csr_data;
               CSR_PRESS_TRIM_B: press_b_ff   <= csr_data;
               CSR_PRESS_TRIM_C: press_c_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.den_zero = (a_ff == 64'd0);

   assign result_value = $signed(out_val_ff);
   assign divide_fault = out_flt_ff;

endmodule

>>> hw/rtl/bmpc_ctrl.sv
// ----------------------------------------------------------------------------
// bmpc_ctrl
// Step sequencer: walks the compensation steps and runs the handshakes.
// ----------------------------------------------------------------------------
module bmpc_ctrl
   import bmpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_WAIT  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   step_type  pc_ff, pc_in;
   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  kind;

   assign kind = step_kind(pc_ff);

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.load     = 1'b0;
      cmd.issue    = 1'b0;
      cmd.retire   = 1'b0;
      cmd.publish  = 1'b0;
      cmd.step     = pc_ff;
      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               pc_in    = req_operation ? P_A : T_A;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            case (kind)
               KIND_MUL, KIND_DIV: state_in = S_WAIT;
               KIND_LAST:          state_in = S_DONE;
               KIND_CHK: begin
                  if (status.den_zero)
                     state_in = S_DONE;
                  else
                     pc_in = step_type'(pc_ff + 5'd1);
               end
               default: pc_in = step_type'(pc_ff + 5'd1);
            endcase
         end
         S_WAIT: begin
            if ((kind == KIND_MUL && status.mul_done) ||
                (kind == KIND_DIV && status.div_done)) begin
               cmd.retire = 1'b1;
               pc_in      = step_type'(pc_ff + 5'd1);
               state_in   = S_ISSUE;
            end
         end
         S_DONE: begin
            // hold the finished value until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= T_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/baro_temp_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Integer temperature and pressure compensation of raw barometer readings.
//
//   channel  ports                               direction
//   req      req_valid/ready, operation, raw    in
//   rsp      rsp_valid/ready, value, fault      out
//   csr      csr_valid/ready, index, data       in, always ready
//
// A pressure transaction ends early when the denominator is zero. The
// shared multiplier is used 3 times for temperature and 10 times for
// pressure, the divider once unless the denominator is zero. One
// transaction is in work at a time; a new one is taken while the last
// result still waits, and a finished one stalls until the output register
// is free.
// Reset is synchronous and clears trims and fine temperature.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top
   import bmpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   input  logic [23:0]             req_raw_reading,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [RES_W-1:0] rsp_result_value,
   output logic                    rsp_divide_fault,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [TRIM_W-1:0]       csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   bmpc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .status        (status)
   );

   bmpc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .raw_reading  (req_raw_reading),
      .csr_write    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .result_value (rsp_result_value),
      .divide_fault (rsp_divide_fault)
   );

endmodule
